// File: rtl/lmd3_pkg.sv
// Package: shared constants and result type of the 3x3 local maximum detector.
`timescale 1ns / 1ps

package lmd3_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_VALUE_BITS = 16;

    localparam int CFG_BITS      = 12;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int ROW_BITS      = 12;
    localparam int POS_BITS      = 11;
    localparam int HEIGHT_LIMIT  = 2048;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = 3;
    localparam int FIFO_CNT_BITS = 4;

    localparam int OUT_DATA_BITS = 24;

    typedef struct packed {
        logic                frame_end;
        logic [POS_BITS-1:0] pixel_col;
        logic [POS_BITS-1:0] pixel_row;
        logic                is_max;
    } result_t;

endpackage

// File: rtl/local_maximum_detector_3x3.sv
// Top level: 3x3 local maximum detector with line store, window and result queue.
`timescale 1ns / 1ps
// Throughput: one pixel item per cycle, sustained; only the result queue can stall the input.
// Path: the item that completes a window (one row and one column later in the stream) is
//   registered with its line store read into stage B, and its result into the queue behind m_tvalid.
// Reset: aresetn synchronous, active low. Clears counters, queue and pipeline valid, and sets
//   width/height to 640/480. The line store is not cleared and needs no clearing pass.

module local_maximum_detector_3x3
    #(
        parameter int MAX_WIDTH  = lmd3_pkg::DEFAULT_MAX_WIDTH,
        parameter int VALUE_BITS = lmd3_pkg::DEFAULT_VALUE_BITS
    )
    (
        input  logic                                  aclk,
        input  logic                                  aresetn,
        // input pixel stream
        input  logic                                  s_tvalid,
        output logic                                  s_tready,
        input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_tdata,  // [VALUE_BITS-1:0] pixel_value
        input  logic                                  s_tuser,  // [0] flush, not read by this block
        // result stream
        output logic                                  m_tvalid,
        input  logic                                  m_tready,
        output logic [lmd3_pkg::OUT_DATA_BITS-1:0]    m_tdata,  // [0] is_max, [11:1] pixel_row,
                                                                // [22:12] pixel_col, [23] zero
        output logic                                  m_tlast,  // frame_end
        // configuration port
        input  logic                                  psel,
        input  logic                                  penable,
        input  logic                                  pwrite,
        input  logic [lmd3_pkg::CFG_ADDR_BITS-1:0]    paddr,
        input  logic [lmd3_pkg::CFG_DATA_BITS-1:0]    pwdata,
        output logic [lmd3_pkg::CFG_DATA_BITS-1:0]    prdata,
        output logic                                  pready
    );

    import lmd3_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RESET_WIDTH_SAT =
        (int'(WIDTH_RESET) > MAX_WIDTH) ? MAX_WIDTH : int'(WIDTH_RESET);
    localparam logic [CW-1:0] RESET_LAST_COL = CW'(RESET_WIDTH_SAT - 1);

    // ---------------------------------------------------------------
    // Configuration registers. Raw values read back; saturated copies
    // drive the datapath. A write restarts the frame.
    // ---------------------------------------------------------------
    logic [CFG_BITS-1:0] width_raw_reg, height_raw_reg;
    logic [CW-1:0]       last_col_reg, last_col_next;
    logic [ROW_BITS-1:0] height_reg, height_next;
    logic                cfg_wr;
    logic                cfg_sel;
    logic [31:0]         wr_val;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[2];
    assign wr_val  = 32'(pwdata[CFG_BITS-1:0]);

    always_comb begin
        // width clamped to 2..MAX_WIDTH, kept as last column index
        if (wr_val < 32'd2) begin
            last_col_next = CW'(1);
        end else if (wr_val > 32'(MAX_WIDTH)) begin
            last_col_next = CW'(MAX_WIDTH - 1);
        end else begin
            last_col_next = CW'(wr_val - 32'd1);
        end
        // height clamped to 2..HEIGHT_LIMIT
        if (wr_val < 32'd2) begin
            height_next = ROW_BITS'(2);
        end else if (wr_val > 32'(HEIGHT_LIMIT)) begin
            height_next = ROW_BITS'(HEIGHT_LIMIT);
        end else begin
            height_next = ROW_BITS'(wr_val);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_raw_reg  <= WIDTH_RESET;
            height_raw_reg <= HEIGHT_RESET;
            last_col_reg   <= RESET_LAST_COL;
            height_reg     <= ROW_BITS'(HEIGHT_RESET);
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_IMAGE_WIDTH: begin
                    width_raw_reg <= pwdata[CFG_BITS-1:0];
                    last_col_reg  <= last_col_next;
                end
                REG_IMAGE_HEIGHT: begin
                    height_raw_reg <= pwdata[CFG_BITS-1:0];
                    height_reg     <= height_next;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_IMAGE_WIDTH:  prdata = CFG_DATA_BITS'(width_raw_reg);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_BITS'(height_raw_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Stage A: accept, raster position, line store read.
    // Row counter runs 0..height; row "height" is the flush row.
    // ---------------------------------------------------------------
    logic                accept;
    logic [CW-1:0]       col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic                at_last_col;

    assign accept      = s_tvalid && s_tready;
    assign at_last_col = (col_reg == last_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_wr) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (at_last_col) begin
                col_reg <= '0;
                row_reg <= (row_reg >= height_reg) ? '0 : row_reg + ROW_BITS'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // Line store: one entry per column holds {row two above, row above}.
    // Consecutive items within a frame always hit different columns, so the write of stage B
    // never collides with the read of stage A.
    logic [2*VALUE_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*VALUE_BITS-1:0] rd_data_reg;

    logic                          b_valid_reg;
    logic [CW-1:0]                 b_col_reg;
    logic [ROW_BITS-1:0]           b_row_reg;
    logic                          b_last_reg;
    logic signed [VALUE_BITS-1:0]  b_bottom_reg;
    logic signed [VALUE_BITS-1:0]  mid_val, top_val;

    assign mid_val = rd_data_reg[VALUE_BITS-1:0];
    assign top_val = rd_data_reg[2*VALUE_BITS-1:VALUE_BITS];

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (b_valid_reg) begin
            line_mem[b_col_reg] <= {mid_val, b_bottom_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_col_reg    <= col_reg;
            b_row_reg    <= row_reg;
            b_last_reg   <= at_last_col;
            b_bottom_reg <= s_tdata[VALUE_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage B: window shift and judgment. Window index is row*3+col,
    // row 0 on top, col 2 newest.
    // ---------------------------------------------------------------
    logic signed [VALUE_BITS-1:0] win_reg  [9];
    logic signed [VALUE_BITS-1:0] win_next [9];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k*3+0] = win_reg[k*3+1];
            win_next[k*3+1] = win_reg[k*3+2];
        end
        win_next[2] = top_val;
        win_next[5] = mid_val;
        win_next[8] = b_bottom_reg;
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            win_reg <= win_next;
        end
    end

    logic    use_top, use_bot, use_left;
    logic    max_a, max_b;
    logic    emit_a, emit_b;
    result_t res_a, res_b;

    assign use_top  = (b_row_reg >= ROW_BITS'(2));
    assign use_bot  = (b_row_reg < height_reg);
    assign use_left = (b_col_reg >= CW'(2));

    always_comb begin
        // centre at window column 1; right column always inside the image
        max_a = (win_next[4] > 0);
        for (int k = 0; k < 3; k++) begin
            if ((k != 0 || use_top) && (k != 2 || use_bot)) begin
                if (use_left && win_next[4] < win_next[k*3+0]) max_a = 1'b0;
                if (k != 1 && win_next[4] < win_next[k*3+1]) max_a = 1'b0;
                if (win_next[4] < win_next[k*3+2]) max_a = 1'b0;
            end
        end
        // last column of the row: centre at window column 2, no right side
        max_b = (win_next[5] > 0);
        for (int k = 0; k < 3; k++) begin
            if ((k != 0 || use_top) && (k != 2 || use_bot)) begin
                if (win_next[5] < win_next[k*3+1]) max_b = 1'b0;
                if (k != 1 && win_next[5] < win_next[k*3+2]) max_b = 1'b0;
            end
        end
    end

    assign emit_a = b_valid_reg && (b_row_reg != '0) && (b_col_reg != '0);
    assign emit_b = emit_a && b_last_reg;

    always_comb begin
        res_a.is_max    = max_a;
        res_a.pixel_row = POS_BITS'(b_row_reg - ROW_BITS'(1));
        res_a.pixel_col = POS_BITS'(b_col_reg - CW'(1));
        res_a.frame_end = 1'b0;
        res_b.is_max    = max_b;
        res_b.pixel_row = POS_BITS'(b_row_reg - ROW_BITS'(1));
        res_b.pixel_col = POS_BITS'(b_col_reg);
        res_b.frame_end = (b_row_reg == height_reg);
    end

    // ---------------------------------------------------------------
    // Result queue. Input is held off unless room for two more items
    // remains after the item in stage B lands.
    // ---------------------------------------------------------------
    result_t                  fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] count_reg;
    logic                     pop;
    logic [FIFO_CNT_BITS-1:0] push_n;
    result_t                  head;

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {1'b0, head.pixel_col, head.pixel_row, head.is_max};
    assign m_tlast  = head.frame_end;
    assign pop      = m_tvalid && m_tready;
    assign push_n   = FIFO_CNT_BITS'(emit_a) + FIFO_CNT_BITS'(emit_b);
    assign s_tready = b_valid_reg ? (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 4))
                                  : (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (emit_a) begin
            fifo_reg[wr_ptr_reg] <= res_a;
        end
        if (emit_b) begin
            fifo_reg[wr_ptr_reg + FIFO_PTR_BITS'(1)] <= res_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(push_n);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(pop);
            count_reg  <= count_reg + push_n - FIFO_CNT_BITS'(pop);
        end
    end

endmodule
